/* rtl/core/i2cbc_pkg.sv */
// ----------------------------------------------------------------------------
// i2cbc_pkg
// Shared types and codes for the I2C bus-clear sequencer.
// ----------------------------------------------------------------------------
package i2cbc_pkg;

  // Register indexes on the configuration port.
  localparam logic CFG_RECOVERY_PULSES   = 1'b0;
  localparam logic CFG_HALF_PERIOD_TICKS = 1'b1;

  // Reset values of the configuration registers.
  localparam logic [4:0]  RECOVERY_PULSES_RST   = 5'd9;
  localparam logic [15:0] HALF_PERIOD_TICKS_RST = 16'd5;

  // Sequence outcome codes.
  typedef enum logic [1:0] {
    OUT_FREE      = 2'd0,
    OUT_RECOVERED = 2'd1,
    OUT_STUCK     = 2'd2
  } outcome_t;

  // Sequencer phases, one-hot.
  typedef enum logic [6:0] {
    PH_IDLE      = 7'b0000001,
    PH_SETTLE    = 7'b0000010,
    PH_SCL_LOW   = 7'b0000100,
    PH_SCL_HIGH  = 7'b0001000,
    PH_STOP_LOW1 = 7'b0010000,
    PH_STOP_LOW2 = 7'b0100000,
    PH_STOP_REL  = 7'b1000000
  } phase_t;

  // One result item.
  typedef struct packed {
    logic       scl_pull_low;
    logic       sda_pull_low;
    logic       busy_res;
    logic       finished;
    logic [1:0] outcome;
  } result_t;

endpackage

/* rtl/core/i2cbc_in_stage.sv */
// ----------------------------------------------------------------------------
// i2cbc_in_stage
// Input register: holds one request until the sequencer consumes it.
// ----------------------------------------------------------------------------
module i2cbc_in_stage (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  logic in_command,
  input  logic in_sda_level,
  output logic stg_valid,
  input  logic stg_take,
  output logic stg_command,
  output logic stg_sda_level
);

  logic valid_r;
  logic command_r;
  logic sda_level_r;

  // The stage accepts a new request when empty or when its current one leaves.
  assign in_ready = !valid_r || stg_take;

  // Valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  // Payload, loaded on acceptance.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      command_r   <= in_command;
      sda_level_r <= in_sda_level;
    end
  end

  assign stg_valid     = valid_r;
  assign stg_command   = command_r;
  assign stg_sda_level = sda_level_r;

endmodule

/* rtl/core/i2cbc_seq.sv */
// ----------------------------------------------------------------------------
// i2cbc_seq
// Bus-clear state machine: phase, half-period timer, pulse counter and
// outcome; advances by one request per enabled cycle.
// ----------------------------------------------------------------------------
module i2cbc_seq
  import i2cbc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step_en,
  input  logic        command,
  input  logic        sda_level,
  input  logic [4:0]  recovery_pulses,
  input  logic [15:0] half_period_ticks,
  output result_t     res
);

  phase_t      phase_r, phase_nxt;
  logic [15:0] delay_r, delay_nxt;
  logic [4:0]  pulse_r, pulse_nxt;
  outcome_t    outcome_r, outcome_nxt;
  logic        done;
  logic [15:0] half_load;
  logic [4:0]  pulse_inc;

  // A zero half period counts as one tick.
  assign half_load = (half_period_ticks == 16'd0) ? 16'd1 : half_period_ticks;
  assign pulse_inc = pulse_r + 5'd1;

  // Next-state logic.
  always_comb begin
    phase_nxt   = phase_r;
    delay_nxt   = delay_r;
    pulse_nxt   = pulse_r;
    outcome_nxt = outcome_r;
    done        = 1'b0;
    if (phase_r == PH_IDLE) begin
      if (command) begin
        pulse_nxt = 5'd0;
        phase_nxt = PH_SETTLE;
        delay_nxt = half_load;
      end
    end else if (delay_r > 16'd1) begin
      delay_nxt = delay_r - 16'd1;
    end else begin
      unique case (phase_r)
        PH_SETTLE: begin
          if (sda_level) begin
            phase_nxt   = PH_IDLE;
            delay_nxt   = 16'd0;
            outcome_nxt = OUT_FREE;
            done        = 1'b1;
          end else begin
            pulse_nxt = 5'd0;
            if (recovery_pulses == 5'd0) begin
              phase_nxt   = PH_IDLE;
              delay_nxt   = 16'd0;
              outcome_nxt = OUT_STUCK;
              done        = 1'b1;
            end else begin
              phase_nxt = PH_SCL_LOW;
              delay_nxt = half_load;
            end
          end
        end
        PH_SCL_LOW: begin
          phase_nxt = PH_SCL_HIGH;
          delay_nxt = half_load;
        end
        PH_SCL_HIGH: begin
          pulse_nxt = pulse_inc;
          if (sda_level) begin
            phase_nxt = PH_STOP_LOW1;
            delay_nxt = half_load;
          end else if (pulse_inc >= recovery_pulses) begin
            phase_nxt   = PH_IDLE;
            delay_nxt   = 16'd0;
            outcome_nxt = OUT_STUCK;
            done        = 1'b1;
          end else begin
            phase_nxt = PH_SCL_LOW;
            delay_nxt = half_load;
          end
        end
        PH_STOP_LOW1: begin
          phase_nxt = PH_STOP_LOW2;
          delay_nxt = half_load;
        end
        PH_STOP_LOW2: begin
          phase_nxt = PH_STOP_REL;
          delay_nxt = half_load;
        end
        PH_STOP_REL: begin
          phase_nxt   = PH_IDLE;
          delay_nxt   = 16'd0;
          outcome_nxt = OUT_RECOVERED;
          done        = 1'b1;
        end
        default: begin
          phase_nxt = PH_IDLE;
          delay_nxt = 16'd0;
        end
      endcase
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      delay_r   <= 16'd0;
      pulse_r   <= 5'd0;
      outcome_r <= OUT_FREE;
    end else if (step_en) begin
      phase_r   <= phase_nxt;
      delay_r   <= delay_nxt;
      pulse_r   <= pulse_nxt;
      outcome_r <= outcome_nxt;
    end
  end

  // Result of the request being processed, taken from the next state.
  always_comb begin
    res.scl_pull_low = (phase_nxt == PH_SCL_LOW);
    res.sda_pull_low = (phase_nxt == PH_STOP_LOW1) || (phase_nxt == PH_STOP_LOW2);
    res.busy_res     = (phase_nxt != PH_IDLE);
    res.finished     = done;
    res.outcome      = outcome_nxt;
  end

endmodule

/* rtl/core/i2c_bus_clear_sequencer_core.sv */
// ----------------------------------------------------------------------------
// i2c_bus_clear_sequencer_core
// Tick-driven I2C bus-clear sequencer with open-drain pull-low outputs.
// ----------------------------------------------------------------------------
// Each request is one time tick or a start command, and each gives exactly
// one result. The block takes one request per clock unless the output stalls.
// A request waits in the input register, the phase, timer and pulse counter
// are updated in a single pass, and the result waits in the result register.
// The result register frees the input side while a result waits, so requests
// keep flowing until both registers are full. Registers must be written by
// the user through cfg_we/cfg_index/cfg_wdata while idle; no check in the block.
module i2c_bus_clear_sequencer_core
  import i2cbc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_command,
  input  logic        in_sda_level,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_scl_pull_low,
  output logic        out_sda_pull_low,
  output logic        out_busy_res,
  output logic        out_finished,
  output logic [1:0]  out_outcome
);

  logic [4:0]  recovery_pulses_r;
  logic [15:0] half_period_ticks_r;
  logic        stg_valid;
  logic        stg_command;
  logic        stg_sda_level;
  logic        advance;
  logic        out_valid_r;
  result_t     res;
  result_t     res_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      recovery_pulses_r   <= RECOVERY_PULSES_RST;
      half_period_ticks_r <= HALF_PERIOD_TICKS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RECOVERY_PULSES:   recovery_pulses_r   <= cfg_wdata[4:0];
        CFG_HALF_PERIOD_TICKS: half_period_ticks_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Input register.
  i2cbc_in_stage u_in_stage (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_command   (in_command),
    .in_sda_level (in_sda_level),
    .stg_valid    (stg_valid),
    .stg_take     (advance),
    .stg_command  (stg_command),
    .stg_sda_level(stg_sda_level)
  );

  // A request moves on when the result register is free or being emptied.
  assign advance = stg_valid && (!out_valid_r || out_ready);

  // Sequencer.
  i2cbc_seq u_seq (
    .clk              (clk),
    .rst_n            (rst_n),
    .step_en          (advance),
    .command          (stg_command),
    .sda_level        (stg_sda_level),
    .recovery_pulses  (recovery_pulses_r),
    .half_period_ticks(half_period_ticks_r),
    .res              (res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      out_valid_r <= stg_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_scl_pull_low = res_r.scl_pull_low;
  assign out_sda_pull_low = res_r.sda_pull_low;
  assign out_busy_res     = res_r.busy_res;
  assign out_finished     = res_r.finished;
  assign out_outcome      = res_r.outcome;

  // A finishing result never reports the sequence as still busy.
  a_finish_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.finished |-> !res_r.busy_res)
    else $error("finished result reports busy");

  // SCL and SDA are never pulled low together.
  a_one_line_low: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(res_r.scl_pull_low && res_r.sda_pull_low))
    else $error("both lines pulled low");

  // The outcome is always a defined code.
  a_outcome_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (res_r.outcome == OUT_FREE || res_r.outcome == OUT_RECOVERED ||
                     res_r.outcome == OUT_STUCK))
    else $error("undefined outcome code");

  // The input side stalls only while both registers are full and output stalls.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (stg_valid && out_valid_r && !out_ready))
    else $error("input stalled without cause");

endmodule
